// ----- src/acl_pkg.sv -----
`timescale 1ns / 1ps

package acl_pkg;

  localparam int CHANNELS   = 2;
  localparam int SMP_W      = 16;
  localparam int COEF_W     = 16;
  localparam int ENV_W      = 24;
  localparam int GAIN_W     = 28;
  localparam int MUL_A_W    = GAIN_W;
  localparam int MUL_B_W    = ENV_W;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int DIV_CNT_W  = $clog2(GAIN_W + 1);
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 19;

  localparam logic [ENV_W-1:0] ONE_Q23 = ENV_W'(1) << (ENV_W - 1);

endpackage

// ----- src/acl_mul.sv -----
`timescale 1ns / 1ps

module acl_mul (
  input  logic                        clk,
  input  logic [acl_pkg::MUL_A_W-1:0] op_a,
  input  logic [acl_pkg::MUL_B_W-1:0] op_b,
  output logic [acl_pkg::PROD_W-1:0]  prod
);
  import acl_pkg::*;

  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
  end

  assign prod = prod_r;

endmodule

// ----- src/acl_div.sv -----
`timescale 1ns / 1ps

module acl_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [acl_pkg::ENV_W-1:0]  rem_init,
  input  logic [acl_pkg::ENV_W-1:0]  divisor,
  output logic                       done,
  output logic [acl_pkg::GAIN_W-1:0] quo
);
  import acl_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ENV_W-1:0]     rem_r, rem_nxt;
  logic [GAIN_W-1:0]    quo_r, quo_nxt;
  logic [ENV_W:0]       rem_sh;
  logic                 fits;

  assign rem_sh = {rem_r, 1'b0};
  assign fits   = rem_sh >= {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = rem_init;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = fits ? ENV_W'(rem_sh - {1'b0, divisor}) : rem_sh[ENV_W-1:0];
      quo_nxt = {quo_r[GAIN_W-2:0], fits};
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(GAIN_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ----- src/audio_compressor_limiter_gate.sv -----
`timescale 1ns / 1ps

// Dynamics processor for one frame of two signed Q1.15 samples per word: a level envelope,
// a peak envelope, a limiter and a noise gate set one gain, which scales both samples with
// saturation. Every gain or output product and every envelope update but a reload of the peak
// envelope from the frame peak runs through a single registered 28x24 multiplier under a
// sequencer, each product set up in an issue state and read in its wait state. When the limiter
// engages, its gain is found by a restoring divider at one quotient bit per cycle. The input is
// stalled while a frame is in work and is taken again in the cycle after the result is written;
// a finished word waits in the output register while the next frame is taken, and a result
// that is still waiting holds the sequencer in its last step. The level envelope cannot rise
// above unity, so the compressor slope never bends the gain; a write to register 0 is accepted
// and has no effect.
module audio_compressor_limiter_gate (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [acl_pkg::SMP_W-1:0]    in_sample_0,
  input  logic signed [acl_pkg::SMP_W-1:0]    in_sample_1,
  input  logic                                in_end_of_chunk,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [acl_pkg::SMP_W-1:0]    out_0,
  output logic signed [acl_pkg::SMP_W-1:0]    out_1,
  output logic [acl_pkg::COEF_W-1:0]          out_applied_gain,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [acl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [acl_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import acl_pkg::*;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RATIO    = 4'd0,
    REG_TRIM     = 4'd1,
    REG_ATTACK   = 4'd2,
    REG_RELEASE  = 4'd3,
    REG_LIMIT    = 4'd4,
    REG_GATE_THR = 4'd5,
    REG_GATE_ATK = 4'd6,
    REG_GATE_REL = 4'd7
  } cfg_idx_t;

  typedef enum logic [15:0] {
    ST_IDLE  = 16'h0001,
    ST_M_E   = 16'h0002,
    ST_W_E   = 16'h0004,
    ST_M_PK  = 16'h0008,
    ST_W_PK  = 16'h0010,
    ST_M_GT  = 16'h0020,
    ST_W_GT  = 16'h0040,
    ST_M_LIM = 16'h0080,
    ST_W_LIM = 16'h0100,
    ST_DIV   = 16'h0200,
    ST_M_FG  = 16'h0400,
    ST_W_FG  = 16'h0800,
    ST_M_O0  = 16'h1000,
    ST_W_O0  = 16'h2000,
    ST_M_O1  = 16'h4000,
    ST_W_O1  = 16'h8000
  } state_t;

  function automatic logic [SMP_W-1:0] sat_out(input logic neg, input logic [GAIN_W-1:0] q);
    logic [SMP_W-1:0] r;
    begin
      if (neg) begin
        r = (q >= GAIN_W'(32768)) ? 16'h8000 : SMP_W'(~q + GAIN_W'(1));
      end else begin
        r = (q >= GAIN_W'(32767)) ? 16'h7fff : q[SMP_W-1:0];
      end
      return r;
    end
  endfunction

  state_t state_r, state_nxt;

  logic [COEF_W-1:0] trim_r, attack_r, release_r, limit_r, gthr_r, gatk_r, grel_r;

  logic [ENV_W-1:0]  lev_r, lev_nxt;
  logic [ENV_W-1:0]  pk_r, pk_nxt;
  logic [ENV_W-1:0]  ge_r, ge_nxt;
  logic [ENV_W-1:0]  cmax_r, cmax_nxt;
  logic [SMP_W-1:0]  mag0_r, mag0_nxt, mag1_r, mag1_nxt;
  logic              neg0_r, neg0_nxt, neg1_r, neg1_nxt;
  logic [GAIN_W-1:0] g_r, g_nxt;
  logic [GAIN_W-1:0] gain_r, gain_nxt;
  logic [SMP_W-1:0]  o0_r, o0_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [SMP_W-1:0]  out0_r, out0_nxt, out1_r, out1_nxt;
  logic [COEF_W-1:0] ag_r, ag_nxt;

  logic [SMP_W-1:0]   in_mag0, in_mag1, in_max;
  logic [MUL_A_W-1:0] op_a;
  logic [MUL_B_W-1:0] op_b;
  logic [PROD_W-1:0]  prod;
  logic [ENV_W-1:0]   prod_env;
  logic               rising, gate_up, in_acc, div_start, div_done;
  logic [GAIN_W-1:0]  div_quo;
  logic [ENV_W-1:0]   gate_rest;

  assign in_acc  = in_valid && !in_stall;
  assign in_mag0 = in_sample_0[SMP_W-1] ? SMP_W'(~in_sample_0 + 1'b1) : in_sample_0;
  assign in_mag1 = (CHANNELS > 1) ?
                   (in_sample_1[SMP_W-1] ? SMP_W'(~in_sample_1 + 1'b1) : in_sample_1) : '0;
  assign in_max  = (in_mag1 > in_mag0) ? in_mag1 : in_mag0;

  assign rising    = cmax_r > lev_r;
  assign gate_up   = lev_r > {gthr_r, 8'b0};
  assign gate_rest = (ge_r < ONE_Q23) ? ONE_Q23 - ge_r : '0;
  assign prod_env  = prod[COEF_W+ENV_W-1:COEF_W];

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_r)
      ST_M_E, ST_W_E: begin
        op_a = MUL_A_W'(rising ? attack_r : release_r);
        op_b = rising ? cmax_r - lev_r : lev_r;
      end
      ST_M_PK, ST_W_PK: begin
        op_a = MUL_A_W'(release_r);
        op_b = pk_r;
      end
      ST_M_GT, ST_W_GT: begin
        op_a = MUL_A_W'(gate_up ? gatk_r : grel_r);
        op_b = gate_up ? gate_rest : ge_r;
      end
      ST_M_LIM, ST_W_LIM: begin
        op_a = g_r;
        op_b = pk_r;
      end
      ST_M_FG, ST_W_FG: begin
        op_a = g_r;
        op_b = ge_r;
      end
      ST_M_O0, ST_W_O0: begin
        op_a = gain_r;
        op_b = MUL_B_W'(mag0_r);
      end
      ST_M_O1, ST_W_O1: begin
        op_a = gain_r;
        op_b = MUL_B_W'(mag1_r);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  acl_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  assign div_start = (state_r == ST_W_LIM) && (limit_r != '0) &&
                     (prod > PROD_W'({limit_r, 35'b0}));

  acl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .rem_init ({1'b0, limit_r, 7'b0}),
    .divisor  (pk_r),
    .done     (div_done),
    .quo      (div_quo)
  );

  always_comb begin
    state_nxt     = state_r;
    lev_nxt       = lev_r;
    pk_nxt        = pk_r;
    ge_nxt        = ge_r;
    cmax_nxt      = cmax_r;
    mag0_nxt      = mag0_r;
    mag1_nxt      = mag1_r;
    neg0_nxt      = neg0_r;
    neg1_nxt      = neg1_r;
    g_nxt         = g_r;
    gain_nxt      = gain_r;
    o0_nxt        = o0_r;
    out_valid_nxt = out_valid_r;
    out0_nxt      = out0_r;
    out1_nxt      = out1_r;
    ag_nxt        = ag_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cmax_nxt  = {in_max, 8'b0};
          mag0_nxt  = in_mag0;
          mag1_nxt  = in_mag1;
          neg0_nxt  = in_sample_0[SMP_W-1];
          neg1_nxt  = in_sample_1[SMP_W-1];
          g_nxt     = {trim_r, 12'b0};
          state_nxt = ST_M_E;
        end
      end
      ST_M_E:   state_nxt = ST_W_E;
      ST_W_E: begin
        lev_nxt   = rising ? lev_r + prod_env : prod_env;
        state_nxt = ST_M_PK;
      end
      ST_M_PK: begin
        if (rising) begin
          pk_nxt    = cmax_r;
          state_nxt = ST_M_GT;
        end else begin
          state_nxt = ST_W_PK;
        end
      end
      ST_W_PK: begin
        pk_nxt    = prod_env;
        state_nxt = ST_M_GT;
      end
      ST_M_GT:  state_nxt = ST_W_GT;
      ST_W_GT: begin
        ge_nxt    = gate_up ? ge_r + prod_env : prod_env;
        state_nxt = ST_M_LIM;
      end
      ST_M_LIM: state_nxt = ST_W_LIM;
      ST_W_LIM: state_nxt = div_start ? ST_DIV : ST_M_FG;
      ST_DIV: begin
        if (div_done) begin
          g_nxt     = div_quo;
          state_nxt = ST_M_FG;
        end
      end
      ST_M_FG:  state_nxt = ST_W_FG;
      ST_W_FG: begin
        gain_nxt  = prod[GAIN_W+ENV_W-2:ENV_W-1];
        state_nxt = ST_M_O0;
      end
      ST_M_O0:  state_nxt = ST_W_O0;
      ST_W_O0: begin
        o0_nxt    = sat_out(neg0_r, prod[PROD_W-1:ENV_W]);
        state_nxt = ST_M_O1;
      end
      ST_M_O1:  state_nxt = ST_W_O1;
      ST_W_O1: begin
        if (!out_valid_r || !out_stall) begin
          out0_nxt      = o0_r;
          out1_nxt      = sat_out(neg1_r, prod[PROD_W-1:ENV_W]);
          ag_nxt        = gain_r[GAIN_W-1:GAIN_W-COEF_W];
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      lev_r       <= '0;
      pk_r        <= '0;
      ge_r        <= '0;
      trim_r      <= 16'd4096;
      attack_r    <= 16'd28476;
      release_r   <= 16'd65521;
      limit_r     <= 16'd4096;
      gthr_r      <= 16'd0;
      gatk_r      <= 16'd32697;
      grel_r      <= 16'd65521;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      lev_r       <= lev_nxt;
      pk_r        <= pk_nxt;
      ge_r        <= ge_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_RATIO:    ;
          REG_TRIM:     trim_r    <= cfg_data[COEF_W-1:0];
          REG_ATTACK:   attack_r  <= cfg_data[COEF_W-1:0];
          REG_RELEASE:  release_r <= cfg_data[COEF_W-1:0];
          REG_LIMIT:    limit_r   <= cfg_data[COEF_W-1:0];
          REG_GATE_THR: gthr_r    <= cfg_data[COEF_W-1:0];
          REG_GATE_ATK: gatk_r    <= cfg_data[COEF_W-1:0];
          REG_GATE_REL: grel_r    <= cfg_data[COEF_W-1:0];
          default:      ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cmax_r <= cmax_nxt;
    mag0_r <= mag0_nxt;
    mag1_r <= mag1_nxt;
    neg0_r <= neg0_nxt;
    neg1_r <= neg1_nxt;
    g_r    <= g_nxt;
    gain_r <= gain_nxt;
    o0_r   <= o0_nxt;
    out0_r <= out0_nxt;
    out1_r <= out1_nxt;
    ag_r   <= ag_nxt;
  end

  assign in_stall         = (state_r != ST_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_0            = out0_r;
  assign out_1            = out1_r;
  assign out_applied_gain = ag_r;

`ifndef SYNTHESIS
  a_lev_unity: assert property (@(posedge clk) disable iff (!rst_n) lev_r <= ONE_Q23)
    else $error("Level envelope above unity.");
  a_pk_unity: assert property (@(posedge clk) disable iff (!rst_n) pk_r <= ONE_Q23)
    else $error("Peak envelope above unity.");
  a_ge_unity: assert property (@(posedge clk) disable iff (!rst_n) ge_r <= ONE_Q23)
    else $error("Gate envelope above unity.");
  a_div_lower: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && div_done) |-> div_quo < g_r)
    else $error("Limiter gain does not lower the gain.");
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (limit_r != '0 && pk_r != '0))
    else $error("Limiter division started without a limit or a peak.");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_M_E)
    else $error("Accepted word did not start the sequencer.");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import acl_pkg::*;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RATIO,
    REG_TRIM_GAIN,
    REG_ATTACK_COEF,
    REG_RELEASE_KEEP,
    REG_LIMIT_LEVEL,
    REG_GATE_THRESHOLD,
    REG_GATE_ATTACK,
    REG_GATE_RELEASE
  } cfg_reg_e;

  typedef enum int {SEG_NOISE, SEG_HUSH, SEG_CORNER, SEG_LOUD} seg_kind_e;

  typedef struct packed {
    logic signed [SMP_W-1:0] s0;
    logic signed [SMP_W-1:0] s1;
    logic [COEF_W-1:0]       gain;
  } frame_result_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] s0;
    logic signed [SMP_W-1:0] s1;
    logic                    eoc;
    logic                    known;
    frame_result_t           result;
  } stim_row_t;

  localparam int REG_COUNT = 8;
  localparam int REG_LAST_INDEX = (1 << CFG_IDX_W) - 1;
  localparam logic [63:0] UNITY = 64'd1 << 23;
  localparam logic [63:0] GAIN_CEILING = (64'd1 << 36) - 64'd1;
  localparam logic signed [SMP_W-1:0] SMP_MIN = 16'sh8000;
  localparam logic signed [SMP_W-1:0] SMP_MAX = 16'sh7FFF;
  localparam int PHASES = 8;
  localparam int FRAMES_PER_PHASE = 235;
  localparam int DRAIN_CYCLES = 60;
  localparam int DIRECTED_ROWS = 20;
  localparam frame_result_t SILENT = '0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SMP_W-1:0] in_sample_0 = '0;
  logic signed [SMP_W-1:0] in_sample_1 = '0;
  logic in_end_of_chunk = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SMP_W-1:0] out_0;
  logic signed [SMP_W-1:0] out_1;
  logic [COEF_W-1:0] out_applied_gain;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic signed [CFG_DATA_W-1:0] ratio_q12;
  logic [COEF_W-1:0] trim_q12, attack_q16, release_q16, limit_q12;
  logic [COEF_W-1:0] gate_thr_q15, gate_attack_q16, gate_release_q16;
  logic [ENV_W-1:0] level_env, peak_env, gate_env;

  frame_result_t expected_q[$];
  logic [CFG_DATA_W-1:0] next_cfg [REG_COUNT];
  logic signed [SMP_W-1:0] corners [6];
  stim_row_t directed [DIRECTED_ROWS];
  int errors = 0;
  int stall_left = 0;
  bit quiet = 1'b0;

  audio_compressor_limiter_gate DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_sample_0(in_sample_0),
    .in_sample_1(in_sample_1),
    .in_end_of_chunk(in_end_of_chunk),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_0(out_0),
    .out_1(out_1),
    .out_applied_gain(out_applied_gain),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void reset_dynamics();
    ratio_q12 = 19'sd2048;
    trim_q12 = 16'd4096;
    attack_q16 = 16'd28476;
    release_q16 = 16'd65521;
    limit_q12 = 16'd4096;
    gate_thr_q15 = 16'd0;
    gate_attack_q16 = 16'd32697;
    gate_release_q16 = 16'd65521;
    level_env = '0;
    peak_env = '0;
    gate_env = '0;
  endfunction

  function automatic void set_dynamics_reg(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_RATIO: ratio_q12 = data;
      REG_TRIM_GAIN: trim_q12 = data[COEF_W-1:0];
      REG_ATTACK_COEF: attack_q16 = data[COEF_W-1:0];
      REG_RELEASE_KEEP: release_q16 = data[COEF_W-1:0];
      REG_LIMIT_LEVEL: limit_q12 = data[COEF_W-1:0];
      REG_GATE_THRESHOLD: gate_thr_q15 = data[COEF_W-1:0];
      REG_GATE_ATTACK: gate_attack_q16 = data[COEF_W-1:0];
      REG_GATE_RELEASE: gate_release_q16 = data[COEF_W-1:0];
      default: ;
    endcase
  endfunction

  // Advances the three envelopes by one frame and returns the scaled frame.
  function automatic frame_result_t scale_frame(logic signed [SMP_W-1:0] s0,
                                                logic signed [SMP_W-1:0] s1);
    logic signed [SMP_W-1:0] smp [2];
    logic [63:0] mag [2];
    logic [63:0] peak, lvl, pk, gt, g, lim, gain, q, rest, ag;
    logic signed [SMP_W-1:0] o [2];
    longint v, den;
    frame_result_t r;
    smp[0] = s0;
    smp[1] = s1;
    for (int k = 0; k < 2; k++) begin
      v = smp[k];
      mag[k] = (v < 0) ? -v : v;
    end
    peak = ((mag[0] > mag[1]) ? mag[0] : mag[1]) << 8;
    lvl = level_env;
    pk = peak_env;
    gt = gate_env;
    if (peak > lvl) lvl = lvl + ((attack_q16 * (peak - lvl)) >> 16);
    else lvl = (lvl * release_q16) >> 16;
    if (peak > lvl) pk = peak;
    else pk = (pk * release_q16) >> 16;
    g = 64'(trim_q12) << 12;
    if (lvl > UNITY) begin
      den = (longint'(1) <<< 35) + longint'(ratio_q12) * (longint'(lvl) - longint'(UNITY));
      g = (den <= 0) ? 64'd0 : (64'(trim_q12) << 47) / 64'(den);
    end
    if (g > GAIN_CEILING) g = GAIN_CEILING;
    if (limit_q12 != 0) begin
      lim = 64'(limit_q12) << 35;
      if (g * pk > lim) g = lim / pk;
    end
    if (lvl > (64'(gate_thr_q15) << 8)) begin
      rest = (gt < UNITY) ? UNITY - gt : 64'd0;
      gt = gt + ((gate_attack_q16 * rest) >> 16);
    end else begin
      gt = (gt * gate_release_q16) >> 16;
    end
    level_env = lvl[ENV_W-1:0];
    peak_env = pk[ENV_W-1:0];
    gate_env = gt[ENV_W-1:0];
    gain = (g * gt) >> 23;
    for (int k = 0; k < 2; k++) begin
      q = (mag[k] * gain) >> 24;
      if (smp[k] < 0) o[k] = (q >= 64'd32768) ? SMP_MIN : SMP_W'(64'd0 - q);
      else o[k] = (q >= 64'd32767) ? SMP_MAX : SMP_W'(q);
    end
    ag = gain >> 12;
    r.s0 = o[0];
    r.s1 = o[1];
    r.gain = (ag > 64'hFFFF) ? 16'hFFFF : ag[COEF_W-1:0];
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    set_dynamics_reg(idx, data);
  endtask

  task automatic load_config();
    write_reg(CFG_IDX_W'($urandom_range(REG_LAST_INDEX, REG_COUNT)), CFG_DATA_W'($urandom));
    for (int i = 0; i < REG_COUNT; i++) write_reg(CFG_IDX_W'(i), next_cfg[i]);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frame(input logic signed [SMP_W-1:0] s0, input logic signed [SMP_W-1:0] s1,
                            input logic eoc, input logic known, input frame_result_t typed);
    int gap;
    frame_result_t want;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_0 <= s0;
    in_sample_1 <= s1;
    in_end_of_chunk <= eoc;
    do @(posedge clk); while (in_stall);
    want = scale_frame(s0, s1);
    expected_q.push_back(known ? typed : want);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected: %0d %0d %0d", out_0, out_1, out_applied_gain);
        errors++;
      end else begin
        want = expected_q.pop_front();
        check_field("out_0", want.s0, out_0);
        check_field("out_1", want.s1, out_1);
        check_field("applied_gain", want.gain, out_applied_gain);
      end
    end
    if (stall_left > 0) stall_left--;
    else stall_left = idle_len();
    out_stall <= (stall_left > 0);
  end

  task automatic pick_config(input int phase);
    case (phase)
      0: begin
        foreach (next_cfg[i]) next_cfg[i] = 19'h7FFFF;
        next_cfg[REG_RATIO] = 19'h3FFFF;
      end
      1: begin
        foreach (next_cfg[i]) next_cfg[i] = '0;
        next_cfg[REG_RATIO] = 19'h7F800;
      end
      2: begin
        foreach (next_cfg[i]) next_cfg[i] = 19'h0FFFF;
        next_cfg[REG_RATIO] = 19'd2048;
        next_cfg[REG_LIMIT_LEVEL] = '0;
        next_cfg[REG_GATE_THRESHOLD] = '0;
      end
      3: begin
        next_cfg[REG_RATIO] = CFG_DATA_W'($urandom);
        next_cfg[REG_TRIM_GAIN] = 19'h0FFFF;
        next_cfg[REG_ATTACK_COEF] = 19'd40000;
        next_cfg[REG_RELEASE_KEEP] = 19'd65000;
        next_cfg[REG_LIMIT_LEVEL] = CFG_DATA_W'($urandom_range(1, 4096));
        next_cfg[REG_GATE_THRESHOLD] = 19'd100;
        next_cfg[REG_GATE_ATTACK] = 19'd60000;
        next_cfg[REG_GATE_RELEASE] = 19'd50000;
      end
      4: begin
        next_cfg[REG_RATIO] = 19'd2048;
        next_cfg[REG_TRIM_GAIN] = 19'd4096;
        next_cfg[REG_ATTACK_COEF] = 19'd28476;
        next_cfg[REG_RELEASE_KEEP] = 19'd65521;
        next_cfg[REG_LIMIT_LEVEL] = 19'd4096;
        next_cfg[REG_GATE_THRESHOLD] = 19'd0;
        next_cfg[REG_GATE_ATTACK] = 19'd32697;
        next_cfg[REG_GATE_RELEASE] = 19'd65521;
      end
      default: begin
        foreach (next_cfg[i]) next_cfg[i] = CFG_DATA_W'($urandom);
        next_cfg[REG_RELEASE_KEEP] = CFG_DATA_W'($urandom_range(50000, 65535));
        next_cfg[REG_GATE_THRESHOLD] = CFG_DATA_W'($urandom_range(0, 32768));
        if ($urandom_range(0, 3) == 0) next_cfg[REG_LIMIT_LEVEL] = '0;
      end
    endcase
  endtask

  task automatic random_frames();
    int seg_left, r;
    seg_kind_e kind;
    logic signed [SMP_W-1:0] s0, s1;
    seg_left = 0;
    kind = SEG_NOISE;
    for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
      if (seg_left == 0) begin
        r = $urandom_range(0, 4);
        kind = (r == 4) ? SEG_NOISE : seg_kind_e'(r);
        seg_left = $urandom_range(1, 40);
        quiet = ($urandom_range(0, 4) == 0);
      end
      seg_left--;
      case (kind)
        SEG_HUSH: begin
          s0 = SMP_W'($urandom_range(0, 128) - 64);
          s1 = SMP_W'($urandom_range(0, 128) - 64);
        end
        SEG_CORNER: begin
          s0 = corners[$urandom_range(0, 5)];
          s1 = corners[$urandom_range(0, 5)];
        end
        SEG_LOUD: begin
          s0 = SMP_W'($urandom_range(24000, 32767));
          s1 = SMP_W'($urandom_range(24000, 32767));
          if ($urandom_range(0, 1) == 1) s0 = -s0;
          if ($urandom_range(0, 1) == 1) s1 = -s1;
        end
        default: begin
          s0 = SMP_W'($urandom);
          s1 = SMP_W'($urandom);
        end
      endcase
      send_frame(s0, s1, $urandom_range(0, 7) == 0, 1'b0, SILENT);
    end
    quiet = 1'b0;
  endtask

  initial begin
    corners = '{SMP_MIN, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, SMP_MAX};
    directed = '{
      '{16'sd0, 16'sd0, 1'b0, 1'b1, SILENT},
      '{16'sd0, 16'sd0, 1'b1, 1'b1, SILENT},
      '{16'sd1, -16'sd1, 1'b0, 1'b0, SILENT},
      '{SMP_MIN, SMP_MAX, 1'b0, 1'b0, SILENT},
      '{SMP_MAX, SMP_MIN, 1'b1, 1'b0, SILENT},
      '{-16'sd1, 16'sd1, 1'b0, 1'b0, SILENT},
      '{16'sd16384, -16'sd16384, 1'b0, 1'b0, SILENT},
      '{SMP_MIN, SMP_MIN, 1'b0, 1'b0, SILENT},
      '{SMP_MAX, SMP_MAX, 1'b0, 1'b0, SILENT},
      '{16'sd21845, -16'sd21846, 1'b0, 1'b0, SILENT},
      '{-16'sd21846, 16'sd21845, 1'b1, 1'b0, SILENT},
      '{16'sd0, SMP_MIN, 1'b0, 1'b0, SILENT},
      '{SMP_MAX, 16'sd0, 1'b0, 1'b0, SILENT},
      '{16'sd0, 16'sd0, 1'b0, 1'b0, SILENT},
      '{16'sd0, 16'sd0, 1'b1, 1'b0, SILENT},
      '{16'sd100, -16'sd100, 1'b0, 1'b0, SILENT},
      '{-16'sd32767, 16'sd1, 1'b0, 1'b0, SILENT},
      '{16'sd0, 16'sd0, 1'b0, 1'b0, SILENT},
      '{16'sd8, -16'sd8, 1'b1, 1'b0, SILENT},
      '{16'sd0, 16'sd0, 1'b0, 1'b0, SILENT}
    };
    reset_dynamics();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i])
      send_frame(directed[i].s0, directed[i].s1, directed[i].eoc, directed[i].known,
                 directed[i].result);
    drain();
    for (int p = 0; p < PHASES; p++) begin
      pick_config(p);
      load_config();
      random_frames();
      drain();
    end
    if (errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
